/* design/cst_pkg.sv */
package cst_pkg;

    localparam int ROW_W = 10;
    localparam int COL_W = 10;
    localparam int VAL_W = 64;
    localparam int IDX_W = 13;
    localparam int PTR_W = 13;
    localparam int DIM_W = 11;

    // Field layout of the input and output beats.
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 88;

    localparam logic CFG_NUM_ROWS = 1'b0;
    localparam logic CFG_NUM_COLS = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_FIN   = 2'd1,
        OP_ENTRY = 2'd2,
        OP_PTR   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_OVERFLOW = 2'd1,
        STAT_RANGE    = 2'd2,
        STAT_NOT_FIN  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        RES_COUNT = 2'd0,
        RES_ERR   = 2'd1,
        RES_ENTRY = 2'd2,
        RES_PTR   = 2'd3
    } res_kind_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_LOAD_WR,
        ST_PRE_RD,
        ST_PRE_WR,
        ST_SC_RD,
        ST_SC_NX,
        ST_SC_WR,
        ST_FIN_DONE,
        ST_RD_ENT,
        ST_RD_PTR,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic      in_cap;
        logic      clr_step;
        logic      load_issue;
        logic      load_commit;
        logic      fin_start;
        logic      pre_rd;
        logic      pre_wr;
        logic      sc_rd;
        logic      sc_nx;
        logic      sc_wr;
        logic      fin_done;
        logic      ent_rd;
        logic      ptr_rd;
        logic      res_set;
        res_kind_t res_kind;
        status_t   res_status;
        logic      out_push;
    } cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    range_err;
        logic    full;
        logic    ent_err;
        logic    ptr_err;
        logic    finalized;
        logic    col_last;
        logic    k_last;
        logic    cnt_zero;
        logic    out_free;
    } stat_t;

endpackage

/* design/cst_ram.sv */
module cst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/cst_ctrl.sv */
module cst_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  cst_pkg::stat_t stat,
    output cst_pkg::cmd_t  cmd
);

    cst_pkg::state_t state_reg;
    cst_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cst_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cst_pkg::ST_CLEAR:
            begin
                if (stat.col_last)
                begin
                    state_next = cst_pkg::ST_IDLE;
                end
            end
            cst_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = cst_pkg::ST_DECODE;
                end
            end
            cst_pkg::ST_DECODE:
            begin
                unique case (stat.op)
                    cst_pkg::OP_LOAD:
                    begin
                        if (stat.range_err || stat.full)
                        begin
                            state_next = cst_pkg::ST_OUT;
                        end
                        else
                        begin
                            state_next = cst_pkg::ST_LOAD_WR;
                        end
                    end
                    cst_pkg::OP_FIN:
                    begin
                        state_next = cst_pkg::ST_PRE_RD;
                    end
                    cst_pkg::OP_ENTRY:
                    begin
                        if (!stat.finalized || stat.ent_err)
                        begin
                            state_next = cst_pkg::ST_OUT;
                        end
                        else
                        begin
                            state_next = cst_pkg::ST_RD_ENT;
                        end
                    end
                    default:
                    begin
                        if (!stat.finalized || stat.ptr_err)
                        begin
                            state_next = cst_pkg::ST_OUT;
                        end
                        else
                        begin
                            state_next = cst_pkg::ST_RD_PTR;
                        end
                    end
                endcase
            end
            cst_pkg::ST_LOAD_WR:
            begin
                state_next = cst_pkg::ST_OUT;
            end
            cst_pkg::ST_PRE_RD:
            begin
                state_next = cst_pkg::ST_PRE_WR;
            end
            cst_pkg::ST_PRE_WR:
            begin
                if (!stat.col_last)
                begin
                    state_next = cst_pkg::ST_PRE_RD;
                end
                else if (stat.cnt_zero)
                begin
                    state_next = cst_pkg::ST_FIN_DONE;
                end
                else
                begin
                    state_next = cst_pkg::ST_SC_RD;
                end
            end
            cst_pkg::ST_SC_RD:
            begin
                state_next = cst_pkg::ST_SC_NX;
            end
            cst_pkg::ST_SC_NX:
            begin
                state_next = cst_pkg::ST_SC_WR;
            end
            cst_pkg::ST_SC_WR:
            begin
                if (stat.k_last)
                begin
                    state_next = cst_pkg::ST_FIN_DONE;
                end
                else
                begin
                    state_next = cst_pkg::ST_SC_RD;
                end
            end
            cst_pkg::ST_FIN_DONE,
            cst_pkg::ST_RD_ENT,
            cst_pkg::ST_RD_PTR:
            begin
                state_next = cst_pkg::ST_OUT;
            end
            cst_pkg::ST_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = cst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cst_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.res_kind   = cst_pkg::RES_COUNT;
        cmd.res_status = cst_pkg::STAT_OK;
        s_tready       = 1'b0;
        unique case (state_reg)
            cst_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            cst_pkg::ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.in_cap = s_tvalid;
            end
            cst_pkg::ST_DECODE:
            begin
                unique case (stat.op)
                    cst_pkg::OP_LOAD:
                    begin
                        if (stat.range_err)
                        begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = cst_pkg::STAT_RANGE;
                        end
                        else if (stat.full)
                        begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = cst_pkg::STAT_OVERFLOW;
                        end
                        else
                        begin
                            cmd.load_issue = 1'b1;
                        end
                    end
                    cst_pkg::OP_FIN:
                    begin
                        cmd.fin_start = 1'b1;
                    end
                    cst_pkg::OP_ENTRY:
                    begin
                        cmd.res_kind = cst_pkg::RES_ERR;
                        if (!stat.finalized)
                        begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = cst_pkg::STAT_NOT_FIN;
                        end
                        else if (stat.ent_err)
                        begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = cst_pkg::STAT_RANGE;
                        end
                        else
                        begin
                            cmd.ent_rd = 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd.res_kind = cst_pkg::RES_ERR;
                        if (!stat.finalized)
                        begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = cst_pkg::STAT_NOT_FIN;
                        end
                        else if (stat.ptr_err)
                        begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = cst_pkg::STAT_RANGE;
                        end
                        else
                        begin
                            cmd.ptr_rd = 1'b1;
                        end
                    end
                endcase
            end
            cst_pkg::ST_LOAD_WR:
            begin
                cmd.load_commit = 1'b1;
                cmd.res_set     = 1'b1;
            end
            cst_pkg::ST_PRE_RD:
            begin
                cmd.pre_rd = 1'b1;
            end
            cst_pkg::ST_PRE_WR:
            begin
                cmd.pre_wr = 1'b1;
            end
            cst_pkg::ST_SC_RD:
            begin
                cmd.sc_rd = 1'b1;
            end
            cst_pkg::ST_SC_NX:
            begin
                cmd.sc_nx = 1'b1;
            end
            cst_pkg::ST_SC_WR:
            begin
                cmd.sc_wr = 1'b1;
            end
            cst_pkg::ST_FIN_DONE:
            begin
                cmd.fin_done = 1'b1;
                cmd.res_set  = 1'b1;
            end
            cst_pkg::ST_RD_ENT:
            begin
                cmd.res_set  = 1'b1;
                cmd.res_kind = cst_pkg::RES_ENTRY;
            end
            cst_pkg::ST_RD_PTR:
            begin
                cmd.res_set  = 1'b1;
                cmd.res_kind = cst_pkg::RES_PTR;
            end
            cst_pkg::ST_OUT:
            begin
                cmd.out_push = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* design/cst_dpath.sv */
module cst_dpath #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 1024,
    parameter int MAX_NNZ  = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_addr,
    input  logic [cst_pkg::DIM_W-1:0]       cfg_wdata,
    input  logic [cst_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cst_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [1:0]                      m_tuser,
    input  cst_pkg::cmd_t                   cmd,
    output cst_pkg::stat_t                  stat
);

    localparam int CNT_W = $clog2(MAX_NNZ + 1);
    localparam int AW_N  = (MAX_NNZ > 1) ? $clog2(MAX_NNZ) : 1;
    localparam int AW_C  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW_P  = $clog2(MAX_COLS + 1);
    localparam int SRC_W = cst_pkg::ROW_W + cst_pkg::COL_W + cst_pkg::VAL_W;
    localparam int OUT_W = cst_pkg::ROW_W + cst_pkg::VAL_W;

    logic [cst_pkg::DIM_W-1:0] num_rows_reg;
    logic [cst_pkg::DIM_W-1:0] num_cols_reg;

    cst_pkg::opcode_t          op_reg;
    logic [cst_pkg::ROW_W-1:0] row_reg;
    logic [cst_pkg::COL_W-1:0] col_reg;
    logic [cst_pkg::VAL_W-1:0] val_reg;
    logic [cst_pkg::IDX_W-1:0] idx_reg;

    logic [CNT_W-1:0] ec_reg,  ec_next;
    logic             fin_reg, fin_next;
    logic [AW_C-1:0]  c_reg,   c_next;
    logic [AW_N-1:0]  k_reg,   k_next;
    logic [CNT_W-1:0] acc_reg, acc_next;
    logic             out_valid_reg, out_valid_next;

    cst_pkg::status_t          res_status_reg;
    logic [cst_pkg::ROW_W-1:0] res_ncol_reg;
    logic [cst_pkg::VAL_W-1:0] res_val_reg;
    logic [cst_pkg::PTR_W-1:0] res_ptr_reg;

    cst_pkg::status_t          out_status_reg;
    logic [cst_pkg::ROW_W-1:0] out_ncol_reg;
    logic [cst_pkg::VAL_W-1:0] out_val_reg;
    logic [cst_pkg::PTR_W-1:0] out_ptr_reg;

    logic [31:0] eff_rows;
    logic [31:0] eff_cols;

    logic [CNT_W-1:0] cnt_rdata;
    logic [CNT_W-1:0] sn_rdata;
    logic [CNT_W-1:0] rp_rdata;
    logic [SRC_W-1:0] src_rdata;
    logic [OUT_W-1:0] out_rdata;

    logic [cst_pkg::ROW_W-1:0] src_row;
    logic [cst_pkg::COL_W-1:0] src_col;
    logic [cst_pkg::VAL_W-1:0] src_val;

    assign src_row = src_rdata[SRC_W-1 -: cst_pkg::ROW_W];
    assign src_col = src_rdata[cst_pkg::VAL_W +: cst_pkg::COL_W];
    assign src_val = src_rdata[cst_pkg::VAL_W-1:0];

    // Zero reads as one, anything above the storage limit reads as the limit.
    always_comb
    begin
        eff_rows = (num_rows_reg == '0) ? 32'd1 :
                   ((32'(num_rows_reg) > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : 32'(num_rows_reg));
        eff_cols = (num_cols_reg == '0) ? 32'd1 :
                   ((32'(num_cols_reg) > 32'(MAX_COLS)) ? 32'(MAX_COLS) : 32'(num_cols_reg));
    end

    always_comb
    begin
        stat.op        = op_reg;
        stat.range_err = (32'(row_reg) >= eff_rows) || (32'(col_reg) >= eff_cols);
        stat.full      = (ec_reg == CNT_W'(MAX_NNZ));
        stat.ent_err   = (32'(idx_reg) >= 32'(ec_reg));
        stat.ptr_err   = (32'(idx_reg) > eff_cols);
        stat.finalized = fin_reg;
        stat.col_last  = (c_reg == AW_C'(MAX_COLS - 1));
        stat.k_last    = ((CNT_W'(k_reg) + CNT_W'(1)) == ec_reg);
        stat.cnt_zero  = (ec_reg == '0);
        stat.out_free  = !out_valid_reg || m_tready;
    end

    always_comb
    begin
        ec_next        = ec_reg + (cmd.load_commit ? CNT_W'(1) : CNT_W'(0));
        fin_next       = fin_reg;
        c_next         = c_reg;
        k_next         = k_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        if (cmd.load_commit)
        begin
            fin_next = 1'b0;
        end
        else if (cmd.fin_done)
        begin
            fin_next = 1'b1;
        end
        if (cmd.fin_start)
        begin
            c_next   = '0;
            k_next   = '0;
            acc_next = '0;
        end
        if (cmd.clr_step || cmd.pre_wr)
        begin
            c_next = stat.col_last ? '0 : c_reg + AW_C'(1);
        end
        if (cmd.pre_wr)
        begin
            acc_next = acc_reg + cnt_rdata;
        end
        if (cmd.sc_wr)
        begin
            k_next = k_reg + AW_N'(1);
        end
        if (cmd.out_push)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg  <= cst_pkg::DIM_W'(1);
            num_cols_reg  <= cst_pkg::DIM_W'(1);
            ec_reg        <= '0;
            fin_reg       <= 1'b0;
            c_reg         <= '0;
            k_reg         <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    cst_pkg::CFG_NUM_ROWS: num_rows_reg <= cfg_wdata;
                    cst_pkg::CFG_NUM_COLS: num_cols_reg <= cfg_wdata;
                    default:               num_rows_reg <= num_rows_reg;
                endcase
            end
            ec_reg        <= ec_next;
            fin_reg       <= fin_next;
            c_reg         <= c_next;
            k_reg         <= k_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_cap)
        begin
            op_reg  <= cst_pkg::opcode_t'(s_tuser);
            row_reg <= s_tdata[9:0];
            col_reg <= s_tdata[19:10];
            val_reg <= s_tdata[83:20];
            idx_reg <= s_tdata[96:84];
        end
        if (cmd.res_set)
        begin
            res_status_reg <= cmd.res_status;
            res_ncol_reg   <= '0;
            res_val_reg    <= '0;
            res_ptr_reg    <= '0;
            case (cmd.res_kind)
                cst_pkg::RES_COUNT: res_ptr_reg <= cst_pkg::PTR_W'(ec_next);
                cst_pkg::RES_ENTRY:
                begin
                    res_ncol_reg <= out_rdata[OUT_W-1 -: cst_pkg::ROW_W];
                    res_val_reg  <= out_rdata[cst_pkg::VAL_W-1:0];
                end
                cst_pkg::RES_PTR:   res_ptr_reg <= cst_pkg::PTR_W'(rp_rdata);
                default:            res_ptr_reg <= '0;
            endcase
        end
        if (cmd.out_push)
        begin
            out_status_reg <= res_status_reg;
            out_ncol_reg   <= res_ncol_reg;
            out_val_reg    <= res_val_reg;
            out_ptr_reg    <= res_ptr_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_ptr_reg, out_val_reg, out_ncol_reg};
    assign m_tuser  = out_status_reg;

    // Column counts: cleared after reset, bumped by each stored load.
    cst_ram #(.WIDTH(CNT_W), .DEPTH(MAX_COLS)) u_cnt_ram (
        .clk   (clk),
        .we    (cmd.clr_step || cmd.load_commit),
        .waddr (cmd.clr_step ? c_reg : AW_C'(col_reg)),
        .wdata (cmd.clr_step ? '0 : cnt_rdata + CNT_W'(1)),
        .re    (cmd.load_issue || cmd.pre_rd),
        .raddr (cmd.pre_rd ? c_reg : AW_C'(col_reg)),
        .rdata (cnt_rdata)
    );

    cst_ram #(.WIDTH(SRC_W), .DEPTH(MAX_NNZ)) u_src_ram (
        .clk   (clk),
        .we    (cmd.load_issue),
        .waddr (AW_N'(ec_reg)),
        .wdata ({row_reg, col_reg, val_reg}),
        .re    (cmd.sc_rd),
        .raddr (k_reg),
        .rdata (src_rdata)
    );

    // Next free slot of each transposed row during the scatter.
    cst_ram #(.WIDTH(CNT_W), .DEPTH(MAX_COLS)) u_sn_ram (
        .clk   (clk),
        .we    (cmd.pre_wr || cmd.sc_wr),
        .waddr (cmd.pre_wr ? c_reg : AW_C'(src_col)),
        .wdata (cmd.pre_wr ? acc_reg : sn_rdata + CNT_W'(1)),
        .re    (cmd.sc_nx),
        .raddr (AW_C'(src_col)),
        .rdata (sn_rdata)
    );

    cst_ram #(.WIDTH(OUT_W), .DEPTH(MAX_NNZ)) u_out_ram (
        .clk   (clk),
        .we    (cmd.sc_wr),
        .waddr (AW_N'(sn_rdata)),
        .wdata ({src_row, src_val}),
        .re    (cmd.ent_rd),
        .raddr (AW_N'(idx_reg)),
        .rdata (out_rdata)
    );

    cst_ram #(.WIDTH(CNT_W), .DEPTH(MAX_COLS + 1)) u_rp_ram (
        .clk   (clk),
        .we    (cmd.fin_start || cmd.pre_wr),
        .waddr (cmd.fin_start ? '0 : AW_P'(c_reg) + AW_P'(1)),
        .wdata (cmd.fin_start ? '0 : acc_reg + cnt_rdata),
        .re    (cmd.ptr_rd),
        .raddr (AW_P'(idx_reg)),
        .rdata (rp_rdata)
    );

    a_ec_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ec_reg <= CNT_W'(MAX_NNZ))
        else $error("entry count beyond store depth");

    a_load_clears_fin: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_commit |=> !fin_reg)
        else $error("stored load left finalized set");

    a_fin_sets: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin_done |=> fin_reg)
        else $error("finalize did not set finalized");

    a_ent_rd_legal: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ent_rd |-> (fin_reg && (32'(idx_reg) < 32'(ec_reg))))
        else $error("entry read outside the filled range");

endmodule

/* design/csr_sparse_transpose_top.sv */
// Each beat is taken in the idle state and answered with one result beat;
// the next beat is taken only once that result has been pushed to the output
// register, which waits while the register is full. Rejected beats go from decode straight to output.
// Finalize runs a prefix walk over the column count memory, then, if any entries
// are stored, a serial scatter of the stored entries.
// After reset the column counts are cleared with s_tready low.
module csr_sparse_transpose_top #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 1024,
    parameter int MAX_NNZ  = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_addr,
    input  logic [cst_pkg::DIM_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // row[9:0], col[19:10], value_bits[83:20], index[96:84], zero fill
    input  logic [cst_pkg::S_TDATA_W-1:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // new_col[9:0], value_out[73:10], pointer[86:74], zero fill
    output logic [cst_pkg::M_TDATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [1:0]                    m_tuser
);

    cst_pkg::cmd_t  cmd;
    cst_pkg::stat_t stat;

    cst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cst_dpath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .MAX_NNZ  (MAX_NNZ)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int N_ROWS_MAX = 1024;
    localparam int N_COLS_MAX = 1024;
    localparam int NNZ_MAX    = 4096;

    typedef struct {
        cst_pkg::opcode_t  op;
        logic [9:0]        row;
        logic [9:0]        col;
        logic [63:0]       val;
        logic [12:0]       idx;
    } cmd_beat_t;

    typedef struct {
        cst_pkg::status_t status;
        logic [9:0]       new_col;
        logic [63:0]      value_out;
        logic [12:0]      pointer;
    } res_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_addr = 1'b0;
    logic [cst_pkg::DIM_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [cst_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [cst_pkg::M_TDATA_W-1:0] m_tdata;
    logic [1:0] m_tuser;

    csr_sparse_transpose_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 clk = ~clk;

    // Shadow of the transpose engine.
    logic [10:0] sh_rows, sh_cols;
    logic [9:0]  sh_src_row [NNZ_MAX];
    logic [9:0]  sh_src_col [NNZ_MAX];
    logic [63:0] sh_src_val [NNZ_MAX];
    int unsigned sh_col_cnt [N_COLS_MAX];
    int unsigned sh_row_ptr [N_COLS_MAX+1];
    logic [9:0]  sh_out_col [NNZ_MAX];
    logic [63:0] sh_out_val [NNZ_MAX];
    int unsigned sh_nnz;
    bit          sh_fin;

    cmd_beat_t pending_cmds[$];
    res_beat_t expected_results[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_recv = 1'b0;
    bit in_taken = 1'b0;

    function automatic int unsigned clamp_dim(logic [10:0] v, int unsigned m);
        if (v == 0) return 1;
        if (v > m) return m;
        return v;
    endfunction

    function automatic void transpose_by_count();
        int unsigned next_slot [N_COLS_MAX];
        int unsigned s;
        sh_row_ptr[0] = 0;
        for (int c = 0; c < N_COLS_MAX; c++) begin
            sh_row_ptr[c+1] = sh_row_ptr[c] + sh_col_cnt[c];
            next_slot[c] = sh_row_ptr[c];
        end
        for (int k = 0; k < sh_nnz; k++) begin
            s = next_slot[sh_src_col[k]];
            if (s < NNZ_MAX) begin
                sh_out_col[s] = sh_src_row[k];
                sh_out_val[s] = sh_src_val[k];
                next_slot[sh_src_col[k]] = s + 1;
            end
        end
        sh_fin = 1'b1;
    endfunction

    function automatic res_beat_t predict_transpose(cmd_beat_t c);
        res_beat_t r;
        int unsigned er, ec;
        er = clamp_dim(sh_rows, N_ROWS_MAX);
        ec = clamp_dim(sh_cols, N_COLS_MAX);
        r.status = cst_pkg::STAT_OK;
        r.new_col = '0;
        r.value_out = '0;
        r.pointer = '0;
        case (c.op)
            cst_pkg::OP_LOAD: begin
                if (c.row >= er || c.col >= ec) r.status = cst_pkg::STAT_RANGE;
                else if (sh_nnz >= NNZ_MAX) r.status = cst_pkg::STAT_OVERFLOW;
                else begin
                    sh_src_row[sh_nnz] = c.row;
                    sh_src_col[sh_nnz] = c.col;
                    sh_src_val[sh_nnz] = c.val;
                    sh_col_cnt[c.col]++;
                    sh_nnz++;
                    sh_fin = 1'b0;
                end
                r.pointer = sh_nnz[12:0];
            end
            cst_pkg::OP_FIN: begin
                transpose_by_count();
                r.pointer = sh_nnz[12:0];
            end
            cst_pkg::OP_ENTRY: begin
                if (!sh_fin) r.status = cst_pkg::STAT_NOT_FIN;
                else if (c.idx >= sh_nnz) r.status = cst_pkg::STAT_RANGE;
                else begin
                    r.new_col = sh_out_col[c.idx];
                    r.value_out = sh_out_val[c.idx];
                end
            end
            default: begin
                if (!sh_fin) r.status = cst_pkg::STAT_NOT_FIN;
                else if (c.idx > ec) r.status = cst_pkg::STAT_RANGE;
                else r.pointer = sh_row_ptr[c.idx][12:0];
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    // Input acceptance is sampled at the rising edge, where the beat is retired.
    always @(posedge clk) begin
        in_taken <= 1'b0;
        if (rst_n && s_tvalid && s_tready) begin
            expected_results.push_back(predict_transpose(pending_cmds.pop_front()));
            in_taken <= 1'b1;
        end
    end

    // Driver: an offered beat is held until it has been accepted.
    always @(negedge clk) begin
        if (rst_n) begin
            if (!s_tvalid || in_taken) begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tuser <= pending_cmds[0].op;
                    s_tdata <= {7'd0, pending_cmds[0].idx, pending_cmds[0].val,
                                pending_cmds[0].col, pending_cmds[0].row};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result beat", 64'(m_tuser), 64'd0);
            end else begin
                res_beat_t e;
                e = expected_results.pop_front();
                if (m_tuser != e.status)
                    report_mismatch("status", 64'(m_tuser), 64'(e.status));
                if (m_tdata[9:0] != e.new_col)
                    report_mismatch("new_col", 64'(m_tdata[9:0]), 64'(e.new_col));
                if (m_tdata[73:10] != e.value_out)
                    report_mismatch("value_out", m_tdata[73:10], e.value_out);
                if (m_tdata[86:74] != e.pointer)
                    report_mismatch("pointer", 64'(m_tdata[86:74]), 64'(e.pointer));
            end
        end
    end

    function automatic cmd_beat_t mk(cst_pkg::opcode_t op, int row, int col, logic [63:0] v,
                                     int idx);
        cmd_beat_t c;
        c.op = op;
        c.row = row[9:0];
        c.col = col[9:0];
        c.val = v;
        c.idx = idx[12:0];
        return c;
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    task automatic drain();
        while (pending_cmds.size() > 0 || expected_results.size() > 0 || s_tvalid)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, int v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= v[cst_pkg::DIM_W-1:0];
        if (idx == cst_pkg::CFG_NUM_ROWS) sh_rows = v[10:0];
        else sh_cols = v[10:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // A matrix: row-major loads with random content, finalize, then reads.
    task automatic queue_matrix(int nnz, int er, int ec);
        int r;
        r = 0;
        for (int k = 0; k < nnz; k++) begin
            if ($urandom_range(99) < 10)
                pending_cmds.push_back(mk(cst_pkg::OP_LOAD, $urandom_range(1023),
                                          $urandom_range(1023), rnd64(),
                                          $urandom_range(8191)));
            r = r + ($urandom_range(2) == 0 ? 1 : 0);
            if (r >= er) r = er - 1;
            pending_cmds.push_back(mk(cst_pkg::OP_LOAD, r, $urandom_range(ec - 1), rnd64(),
                                      $urandom_range(8191)));
        end
        pending_cmds.push_back(mk(cst_pkg::OP_FIN, 0, 0, rnd64(), 0));
        for (int k = 0; k < nnz / 2 + 2; k++) begin
            pending_cmds.push_back(mk(cst_pkg::OP_ENTRY, 0, 0, 0,
                $urandom_range(9) == 0 ? $urandom_range(8191) : $urandom_range(sh_nnz + nnz + 2)));
            pending_cmds.push_back(mk(cst_pkg::OP_PTR, 0, 0, 0,
                $urandom_range(9) == 0 ? $urandom_range(8191) : $urandom_range(ec + 1)));
        end
    endtask

    initial begin
        int tail_n;
        sh_rows = 1;
        sh_cols = 1;
        sh_nnz = 0;
        sh_fin = 1'b0;
        foreach (sh_col_cnt[i]) sh_col_cnt[i] = 0;
        foreach (sh_row_ptr[i]) sh_row_ptr[i] = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reads before finalize, empty matrix, range and extremes.
        pending_cmds.push_back(mk(cst_pkg::OP_ENTRY, 0, 0, 0, 0));
        pending_cmds.push_back(mk(cst_pkg::OP_PTR, 0, 0, 0, 0));
        pending_cmds.push_back(mk(cst_pkg::OP_FIN, 0, 0, 0, 0));
        pending_cmds.push_back(mk(cst_pkg::OP_PTR, 0, 0, 0, 1));
        pending_cmds.push_back(mk(cst_pkg::OP_PTR, 0, 0, 0, 2));
        pending_cmds.push_back(mk(cst_pkg::OP_ENTRY, 0, 0, 0, 0));
        pending_cmds.push_back(mk(cst_pkg::OP_LOAD, 1, 0, 64'h1, 0));
        pending_cmds.push_back(mk(cst_pkg::OP_LOAD, 0, 1, 64'h2, 0));
        pending_cmds.push_back(mk(cst_pkg::OP_LOAD, 0, 0, '1, 8191));
        pending_cmds.push_back(mk(cst_pkg::OP_ENTRY, 0, 0, 0, 0));
        pending_cmds.push_back(mk(cst_pkg::OP_FIN, 0, 0, 0, 0));
        pending_cmds.push_back(mk(cst_pkg::OP_FIN, 0, 0, 0, 0));
        pending_cmds.push_back(mk(cst_pkg::OP_ENTRY, 0, 0, 0, 0));
        pending_cmds.push_back(mk(cst_pkg::OP_ENTRY, 0, 0, 0, 1));
        pending_cmds.push_back(mk(cst_pkg::OP_PTR, 0, 0, 0, 8191));
        drain();

        write_reg(cst_pkg::CFG_NUM_ROWS, 1024);
        write_reg(cst_pkg::CFG_NUM_COLS, 1024);
        pending_cmds.push_back(mk(cst_pkg::OP_LOAD, 1023, 1023, 64'hAAAA_5555_AAAA_5555, 0));
        pending_cmds.push_back(mk(cst_pkg::OP_LOAD, 5, 1023, 64'h5555_AAAA_5555_AAAA, 0));
        pending_cmds.push_back(mk(cst_pkg::OP_LOAD, 0, 0, '0, 0));
        pending_cmds.push_back(mk(cst_pkg::OP_FIN, 0, 0, 0, 0));
        pending_cmds.push_back(mk(cst_pkg::OP_PTR, 0, 0, 0, 1024));
        pending_cmds.push_back(mk(cst_pkg::OP_PTR, 0, 0, 0, 1025));
        pending_cmds.push_back(mk(cst_pkg::OP_ENTRY, 0, 0, 0, 3));
        pending_cmds.push_back(mk(cst_pkg::OP_ENTRY, 0, 0, 0, 4));
        drain();

        // Random phases with different shapes and idling.
        for (int ph = 0; ph < 8; ph++) begin
            int er, ec;
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            er = (ph == 3) ? 1024 : (ph == 5 ? 0 : $urandom_range(1, 40));
            ec = (ph == 4) ? 1 : (ph == 6 ? 2047 : $urandom_range(1, 40));
            write_reg(cst_pkg::CFG_NUM_ROWS, er);
            write_reg(cst_pkg::CFG_NUM_COLS, ec);
            er = clamp_dim(11'(er), N_ROWS_MAX);
            ec = clamp_dim(11'(ec), N_COLS_MAX);
            queue_matrix(45, er, ec);
            if (ph == 2) begin
                // Hold the receiver off long enough for the input to back up.
                hold_recv = 1'b1;
                repeat (400) @(posedge clk);
                hold_recv = 1'b0;
            end
            drain();
        end

        // A last batch on the full-size shape, then reads at the boundaries.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_reg(cst_pkg::CFG_NUM_ROWS, 1024);
        write_reg(cst_pkg::CFG_NUM_COLS, 1024);
        tail_n = sh_nnz + 40;
        for (int k = 0; k < 40; k++)
            pending_cmds.push_back(mk(cst_pkg::OP_LOAD, 1023, $urandom_range(1023), rnd64(), 0));
        pending_cmds.push_back(mk(cst_pkg::OP_FIN, 0, 0, 0, 0));
        pending_cmds.push_back(mk(cst_pkg::OP_PTR, 0, 0, 0, 1024));
        pending_cmds.push_back(mk(cst_pkg::OP_ENTRY, 0, 0, 0, tail_n - 1));
        pending_cmds.push_back(mk(cst_pkg::OP_ENTRY, 0, 0, 0, tail_n));
        drain();

        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    initial begin
        #60ms;
        $display("FAIL");
        $finish;
    end
endmodule
